/* src/job_shop_schedule_builder_defines.svh */
// Assertion macros used by the checker.
`ifndef JOB_SHOP_SCHEDULE_BUILDER_DEFINES_SVH
`define JOB_SHOP_SCHEDULE_BUILDER_DEFINES_SVH

// Same-cycle implication.
`define JSSB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define JSSB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/jssb_pkg.sv */
`timescale 1ns / 1ps

package jssb_pkg;

  localparam int ID_BITS  = 4;
  localparam int JOB_BITS = 4;
  localparam int DUR_BITS = 16;
  localparam int OUT_BITS = 24;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FULL = 1'b1;

endpackage

/* src/jssb_ram.sv */
`timescale 1ns / 1ps

module jssb_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/jssb_time_unit.sv */
`timescale 1ns / 1ps

module jssb_time_unit #(
  parameter int TIME_BITS = 24
) (
  input  logic [TIME_BITS-1:0]          a,
  input  logic [TIME_BITS-1:0]          b,
  input  logic [jssb_pkg::DUR_BITS-1:0] add,
  output logic [TIME_BITS-1:0]          max_v,
  output logic [TIME_BITS-1:0]          sum_sat
);

  localparam int SW = ((TIME_BITS > jssb_pkg::DUR_BITS) ? TIME_BITS : jssb_pkg::DUR_BITS) + 1;

  logic [SW-1:0] sum;
  logic [SW-1:0] lim;

  assign max_v = (a > b) ? a : b;
  assign sum   = SW'(max_v) + SW'(add);
  assign lim   = SW'({TIME_BITS{1'b1}});
  assign sum_sat = (sum > lim) ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

endmodule

/* src/job_shop_schedule_builder.sv */
`timescale 1ns / 1ps

// Job-shop schedule builder.
// Command channel: an item (cmd, job_id, op_index, machine_id, prev_machine_id,
// duration) transfers on a rising edge with start high and busy low.
// Result channel: done is high for exactly one cycle with start_time, end_time,
// span_now and status valid; the receiver cannot stall it.
// Order: a clear answers in the cycle after its transfer. Allocate and query
// step through MREQ, MDAT, SRCH while the previous machine's list is searched
// (skipped when no search is needed), CALC and WR; busy is low again in the
// cycle done is shown.
// The cost is set by the search of the entry RAM through its one read port,
// one entry read per cycle, plus one read for the machine's last finish and
// one write-back.
// A new item can transfer in the same cycle that done is high.
// Reset empties every machine list and zeroes the makespan at once; the entry
// RAM itself is not cleared, only entries below a list's fill are used.
module job_shop_schedule_builder #(
  parameter int MAX_MACHINES = 16,
  parameter int MAX_JOBS     = 16,
  parameter int TIME_BITS    = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    cmd,
  input  logic [jssb_pkg::JOB_BITS-1:0] job_id,
  input  logic [3:0]                    op_index,
  input  logic [jssb_pkg::ID_BITS-1:0]  machine_id,
  input  logic [jssb_pkg::ID_BITS-1:0]  prev_machine_id,
  input  logic [jssb_pkg::DUR_BITS-1:0] duration,
  output logic                          done,
  output logic [jssb_pkg::OUT_BITS-1:0] start_time,
  output logic [jssb_pkg::OUT_BITS-1:0] end_time,
  output logic [jssb_pkg::OUT_BITS-1:0] span_now,
  output logic                          status
);

  localparam int MB  = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int JB  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int FB  = $clog2(MAX_JOBS + 1);
  localparam int AB  = MB + JB;
  localparam int RAM_DEPTH = 1 << AB;
  localparam int EW  = jssb_pkg::JOB_BITS + TIME_BITS;
  localparam int MBX = (MB > jssb_pkg::ID_BITS) ? MB : jssb_pkg::ID_BITS;
  localparam int TX  = (TIME_BITS > jssb_pkg::OUT_BITS) ? TIME_BITS : jssb_pkg::OUT_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MREQ = 3'd1;
  localparam logic [2:0] S_MDAT = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_CALC = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       done_next;

  logic [1:0]                    item_cmd;
  logic [jssb_pkg::JOB_BITS-1:0] item_job;
  logic                          item_first;
  logic [MB-1:0]                 item_mach;
  logic                          item_mach_ok;
  logic [MB-1:0]                 item_pm;
  logic                          item_pm_ok;
  logic [jssb_pkg::DUR_BITS-1:0] item_dur;

  logic [FB-1:0]        list_fill [MAX_MACHINES];
  logic [FB-1:0]        mfill;
  logic [FB-1:0]        pfill;
  logic [FB-1:0]        scan_idx;
  logic                 chk_valid;
  logic                 chk_last;
  logic [TIME_BITS-1:0] mend;
  logic [TIME_BITS-1:0] pfin;
  logic [TIME_BITS-1:0] start_t;
  logic [TIME_BITS-1:0] end_t;
  logic [TIME_BITS-1:0] span;

  logic                 accept;
  logic [MBX-1:0]       mach_x;
  logic [MBX-1:0]       pm_x;
  logic [MB-1:0]        fill_idx;
  logic [FB-1:0]        fill_rd;
  logic [FB-1:0]        fill_dec;
  logic [FB-1:0]        scan_inc;
  logic                 issuing;
  logic                 can_store;

  logic                 ram_we;
  logic [AB-1:0]        ram_waddr;
  logic [EW-1:0]        ram_wdata;
  logic [AB-1:0]        ram_raddr;
  logic [EW-1:0]        ram_rdata;
  logic [jssb_pkg::JOB_BITS-1:0] rd_job;
  logic [TIME_BITS-1:0] rd_finish;

  logic [TIME_BITS-1:0]          tu_a;
  logic [TIME_BITS-1:0]          tu_b;
  logic [jssb_pkg::DUR_BITS-1:0] tu_add;
  logic [TIME_BITS-1:0]          tu_max;
  logic [TIME_BITS-1:0]          tu_sum;

  logic [TIME_BITS-1:0] span_sel;
  logic [TX-1:0]        start_x;
  logic [TX-1:0]        end_x;
  logic [TX-1:0]        span_x;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign mach_x  = MBX'(machine_id);
  assign pm_x    = MBX'(prev_machine_id);

  assign done_next = (state == S_WR) || (accept && (cmd == jssb_pkg::CMD_CLEAR));

  assign fill_idx = (state == S_MDAT) ? item_pm : item_mach;
  assign fill_rd  = list_fill[fill_idx];
  assign fill_dec = fill_rd - 1'b1;
  assign scan_inc = scan_idx + 1'b1;
  assign issuing  = (scan_idx != pfill);
  assign can_store = item_mach_ok && (mfill != FB'(MAX_JOBS));

  assign rd_job    = ram_rdata[EW-1 -: jssb_pkg::JOB_BITS];
  assign rd_finish = ram_rdata[TIME_BITS-1:0];

  assign ram_raddr = (state == S_SRCH) ? {item_pm, scan_idx[JB-1:0]}
                                       : {item_mach, fill_dec[JB-1:0]};
  assign ram_we    = (state == S_WR) && (item_cmd == jssb_pkg::CMD_ALLOC) && can_store;
  assign ram_waddr = {item_mach, mfill[JB-1:0]};
  assign ram_wdata = {item_job, end_t};

  jssb_ram #(
    .WIDTH (EW),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared max / saturating-add unit: start and end in CALC, makespan in WR.
  assign tu_a   = (state == S_WR) ? span  : mend;
  assign tu_b   = (state == S_WR) ? end_t : pfin;
  assign tu_add = (state == S_WR) ? '0    : item_dur;

  jssb_time_unit #(
    .TIME_BITS (TIME_BITS)
  ) u_time (
    .a       (tu_a),
    .b       (tu_b),
    .add     (tu_add),
    .max_v   (tu_max),
    .sum_sat (tu_sum)
  );

  assign span_sel = ram_we ? tu_max : span;
  assign start_x  = TX'(start_t);
  assign end_x    = TX'(end_t);
  assign span_x   = TX'(span_sel);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (cmd != jssb_pkg::CMD_CLEAR)) begin
          state_next = S_MREQ;
        end
      end
      S_MREQ: state_next = S_MDAT;
      S_MDAT: begin
        if (item_first || !item_pm_ok || (fill_rd == '0)) begin
          state_next = S_CALC;
        end else begin
          state_next = S_SRCH;
        end
      end
      S_SRCH: begin
        if (chk_valid && ((rd_job == item_job) || chk_last)) begin
          state_next = S_CALC;
        end
      end
      S_CALC: state_next = S_WR;
      S_WR:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      span  <= '0;
      for (int i = 0; i < MAX_MACHINES; i++) begin
        list_fill[i] <= '0;
      end
    end else begin
      state <= state_next;
      done  <= done_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            item_cmd     <= cmd;
            item_job     <= job_id;
            item_first   <= (op_index == '0);
            item_mach    <= mach_x[MB-1:0];
            item_mach_ok <= (32'(machine_id) < 32'(MAX_MACHINES));
            item_pm      <= pm_x[MB-1:0];
            item_pm_ok   <= (32'(prev_machine_id) < 32'(MAX_MACHINES));
            item_dur     <= duration;
            if (cmd == jssb_pkg::CMD_CLEAR) begin
              for (int i = 0; i < MAX_MACHINES; i++) begin
                list_fill[i] <= '0;
              end
              span       <= '0;
              start_time <= '0;
              end_time   <= '0;
              span_now   <= '0;
              status     <= jssb_pkg::STAT_OK;
            end
          end
        end
        S_MREQ: begin
          mfill <= item_mach_ok ? fill_rd : '0;
        end
        S_MDAT: begin
          mend      <= (mfill != '0) ? rd_finish : '0;
          pfin      <= '0;
          pfill     <= fill_rd;
          scan_idx  <= '0;
          chk_valid <= 1'b0;
          chk_last  <= 1'b0;
        end
        S_SRCH: begin
          if (issuing) begin
            scan_idx <= scan_inc;
          end
          chk_valid <= issuing;
          chk_last  <= (scan_inc == pfill);
          if (chk_valid && (rd_job == item_job)) begin
            pfin <= rd_finish;
          end
        end
        S_CALC: begin
          start_t <= tu_max;
          end_t   <= tu_sum;
        end
        S_WR: begin
          if (ram_we) begin
            list_fill[item_mach] <= mfill + 1'b1;
            span <= tu_max;
          end
          start_time <= start_x[jssb_pkg::OUT_BITS-1:0];
          end_time   <= end_x[jssb_pkg::OUT_BITS-1:0];
          span_now   <= span_x[jssb_pkg::OUT_BITS-1:0];
          status     <= ((item_cmd == jssb_pkg::CMD_ALLOC) && !can_store)
                        ? jssb_pkg::STAT_FULL : jssb_pkg::STAT_OK;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* src/jssb_checker.sv */
`timescale 1ns / 1ps
`include "job_shop_schedule_builder_defines.svh"

module jssb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [1:0]                    cmd,
  input logic                          done,
  input logic [jssb_pkg::OUT_BITS-1:0] start_time,
  input logic [jssb_pkg::OUT_BITS-1:0] end_time,
  input logic [jssb_pkg::OUT_BITS-1:0] span_now,
  input logic                          status
);

  `JSSB_ASSERT_NEXT(a_clear_result, start && !busy && (cmd == jssb_pkg::CMD_CLEAR), done && (start_time == '0) && (end_time == '0) && (span_now == '0) && (status == jssb_pkg::STAT_OK), "clear must answer next cycle with zeros")
  `JSSB_ASSERT_NEXT(a_work_holds_busy, start && !busy && (cmd != jssb_pkg::CMD_CLEAR), busy && !done, "allocate or query must hold busy with no result")
  `JSSB_ASSERT_NOW(a_done_idle, done, !busy, "result must come with the block ready")

endmodule

bind job_shop_schedule_builder jssb_checker u_jssb_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .cmd        (cmd),
  .done       (done),
  .start_time (start_time),
  .end_time   (end_time),
  .span_now   (span_now),
  .status     (status)
);
